>>> src/idq_pkg.sv
package idq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_PEEK_AT    = 3'd3,
    OP_REMOVE_AT  = 3'd4,
    OP_REMOVE_VAL = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Broadcast control that every cell of the chain sees in the execute cycle.
  typedef struct packed {
    logic en;
    logic push_front;
    logic push_back;
    logic full;
    logic by_pos;
    logic by_value;
    logic remove;
  } cell_ctl_t;

endpackage

>>> src/idq_cell.sv
module idq_cell #(
  parameter int INDEX       = 0,
  parameter int CNT_W       = 5,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  idq_pkg::cell_ctl_t     ctl,
  input  logic [CNT_W-1:0]       count,
  input  logic [3:0]             position,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic [VALUE_WIDTH-1:0] prev_data,
  input  logic [VALUE_WIDTH-1:0] next_data,
  input  logic                   found_in,
  input  logic [VALUE_WIDTH-1:0] rd_in,
  output logic                   found_out,
  output logic [VALUE_WIDTH-1:0] rd_out,
  output logic [VALUE_WIDTH-1:0] data
);
  import idq_pkg::*;

  logic live;
  logic pos_hit;
  logic sel;
  logic first;

  assign live    = CNT_W'(INDEX) < count;
  assign pos_hit = {{CNT_W{1'b0}}, position} == (CNT_W + 4)'(INDEX);
  assign sel     = live & ((ctl.by_pos & pos_hit) | (ctl.by_value & (data == value)));
  assign first   = sel & ~found_in;

  // Once an earlier cell has matched, every later cell is part of the gap closing.
  assign found_out = found_in | sel;
  assign rd_out    = rd_in | (first ? data : '0);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.push_front && !ctl.full) begin
        data <= prev_data;
      end else if (ctl.push_back && !ctl.full && count == CNT_W'(INDEX)) begin
        data <= value;
      end else if (ctl.remove && found_out) begin
        data <= next_data;
      end
    end
  end

endmodule

>>> src/indexed_deque.sv
// Ordered queue of up to DEPTH values with push at either end, pop from the
// front, peek or remove at a position, and remove of the first equal value.
// Input channel: in_valid/in_stall carry opcode, value and position. Output
// channel: out_valid/out_stall carry result_value, status and occupancy.
// Every input item yields exactly one result item.
// Each entry lives in a cell of a chain; in the execute cycle all cells
// compare in parallel and shift toward their neighbor in one step.
// The accepted item is registered, and its result is registered in the output
// register when the execute step fires. No new item is taken until the current
// one has executed, a pace set by the single execute step of the cell chain.
// The input is stalled during the execute cycle, and also held there while
// the output register is still full and out_stall is high; a finished result
// waits in the output register while the next item is accepted.
// Reset (rst, synchronous) empties the queue, clears out_valid and returns to
// idle; entry contents are not cleared and are never read before being written.
module indexed_deque #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       opcode,
  input  logic [31:0]      value,
  input  logic [3:0]       position,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      result_value,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] occupancy
);
  import idq_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [2:0]             op_q;
  logic [31:0]            val_q;
  logic [3:0]             pos_q;
  logic [CNT_W-1:0]       count;
  logic [VALUE_WIDTH-1:0] val_m;
  logic [VALUE_WIDTH-1:0] rd_res;
  logic [3:0]             pos_eff;
  logic                   fire;
  logic                   accept;
  logic                   found;
  cell_ctl_t              ctl;
  logic [1:0]             status_next;
  logic [CNT_W-1:0]       count_next;

  logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH:0]         found_chain;
  logic [VALUE_WIDTH-1:0] rd_chain [DEPTH+1];

  generate
    if (VALUE_WIDTH >= 32) begin : g_wide
      assign val_m        = VALUE_WIDTH'(val_q);
      assign result_value = rd_res[31:0];
    end else begin : g_narrow
      assign val_m        = val_q[VALUE_WIDTH-1:0];
      assign result_value = 32'(rd_res);
    end
  endgenerate

  assign in_stall = (state == S_EXEC);
  assign accept   = in_valid & ~in_stall;
  assign fire     = (state == S_EXEC) & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= opcode;
      val_q <= value;
      pos_q <= position;
    end
  end

  // Decode the held item into the control broadcast to the cells.
  always_comb begin
    ctl         = '0;
    ctl.en      = fire;
    ctl.full    = (count == CNT_W'(DEPTH));
    pos_eff     = pos_q;
    case (op_q)
      OP_PUSH_FRONT: ctl.push_front = 1'b1;
      OP_PUSH_BACK:  ctl.push_back  = 1'b1;
      OP_POP_FRONT: begin
        ctl.by_pos = 1'b1;
        ctl.remove = 1'b1;
        pos_eff    = '0;
      end
      OP_PEEK_AT:    ctl.by_pos = 1'b1;
      OP_REMOVE_AT: begin
        ctl.by_pos = 1'b1;
        ctl.remove = 1'b1;
      end
      OP_REMOVE_VAL: begin
        ctl.by_value = 1'b1;
        ctl.remove   = 1'b1;
      end
      default: ;
    endcase
  end

  assign found_chain[0] = 1'b0;
  assign rd_chain[0]    = '0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_d;
      logic [VALUE_WIDTH-1:0] next_d;
      if (i == 0) begin : g_first
        assign prev_d = val_m;
      end else begin : g_mid
        assign prev_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_d = cell_data[i];
      end else begin : g_inner
        assign next_d = cell_data[i+1];
      end
      idq_cell #(
        .INDEX      (i),
        .CNT_W      (CNT_W),
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .count    (count),
        .position (pos_eff),
        .value    (val_m),
        .prev_data(prev_d),
        .next_data(next_d),
        .found_in (found_chain[i]),
        .rd_in    (rd_chain[i]),
        .found_out(found_chain[i+1]),
        .rd_out   (rd_chain[i+1]),
        .data     (cell_data[i])
      );
    end
  endgenerate

  assign found  = found_chain[DEPTH];

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    if ((ctl.push_front || ctl.push_back) && ctl.full) begin
      status_next = ST_FULL;
    end else if (ctl.push_front || ctl.push_back) begin
      count_next = count + 1'b1;
    end else if (ctl.by_pos && !found) begin
      status_next = ST_RANGE;
    end else if (ctl.by_value && !found) begin
      status_next = ST_NOT_FOUND;
    end else if (ctl.remove) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_res    <= rd_chain[DEPTH];
      status    <= status_next;
      occupancy <= count_next;
    end
  end

endmodule

>>> tb/tb_indexed_deque.sv
module tb_indexed_deque;
  import idq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 20;

  // Opcodes that the block must ignore.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // Stall patterns for the result channel.
  localparam int STALL_NONE     = 0;
  localparam int STALL_LIGHT    = 1;
  localparam int STALL_RUNS     = 2;
  localparam int STALL_PERIODIC = 3;

  typedef struct {
    logic [31:0]      res;
    logic [1:0]       st;
    logic [CNT_W-1:0] occ;
  } deque_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       opcode = 3'd0;
  logic [31:0]      value = 32'd0;
  logic [3:0]       position = 4'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      result_value;
  logic [1:0]       status;
  logic [CNT_W-1:0] occupancy;

  logic [31:0]   model_entries[$];
  deque_result_t pending_results[$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            stall_mode = STALL_NONE;
  int            stall_left = 0;

  indexed_deque #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .status(status),
    .occupancy(occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_indexed_deque NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case (stall_mode)
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_RUNS: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_left <= $urandom_range(0, 7);
        end
        STALL_PERIODIC: out_stall <= ((cycle_count % 5) < 2);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Applies one operation to the model queue and returns what the block owes.
  function automatic deque_result_t apply_queue_op(input logic [2:0] op,
                                                   input logic [31:0] val,
                                                   input logic [3:0] pos);
    deque_result_t r;
    bit            found;
    r.res = 32'd0;
    r.st  = ST_OK;
    found = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (model_entries.size() >= DEPTH) r.st = ST_FULL;
        else model_entries.push_front(val);
      end
      OP_PUSH_BACK: begin
        if (model_entries.size() >= DEPTH) r.st = ST_FULL;
        else model_entries.push_back(val);
      end
      OP_POP_FRONT: begin
        if (model_entries.size() == 0) r.st = ST_RANGE;
        else r.res = model_entries.pop_front();
      end
      OP_PEEK_AT: begin
        if (int'(pos) >= model_entries.size()) r.st = ST_RANGE;
        else r.res = model_entries[pos];
      end
      OP_REMOVE_AT: begin
        if (int'(pos) >= model_entries.size()) begin
          r.st = ST_RANGE;
        end else begin
          r.res = model_entries[pos];
          model_entries.delete(pos);
        end
      end
      OP_REMOVE_VAL: begin
        r.st = ST_NOT_FOUND;
        for (int i = 0; i < model_entries.size(); i++) begin
          if (!found && model_entries[i] == val) begin
            found = 1'b1;
            r.res = model_entries[i];
            r.st  = ST_OK;
            model_entries.delete(i);
          end
        end
      end
      default: ;
    endcase
    r.occ = CNT_W'(model_entries.size());
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h status %0d occ %0d",
                 $time, result_value, status, occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("result_value", want.res, result_value);
        report_field("status", 32'(want.st), 32'(status));
        report_field("occupancy", 32'(want.occ), 32'(occupancy));
      end
    end
  end

  // Leaves in_valid high so that a following item goes out back to back.
  task automatic send_item(input logic [2:0] op, input logic [31:0] val,
                           input logic [3:0] pos);
    opcode   <= op;
    value    <= val;
    position <= pos;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_queue_op(op, val, pos));
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_position();
    if (model_entries.size() > 0 && $urandom_range(0, 9) < 8)
      return 4'($urandom_range(0, model_entries.size() - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && model_entries.size() > 0)
      return model_entries[$urandom_range(0, model_entries.size() - 1)];
    if (r == 4) return 32'd0;
    if (r == 5) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic test_directed();
    send_item(OP_POP_FRONT, 32'd0, 4'd0);
    send_item(OP_PEEK_AT, 32'd0, 4'd0);
    send_item(OP_REMOVE_AT, 32'hFFFF_FFFF, 4'd15);
    send_item(OP_REMOVE_VAL, 32'd0, 4'd0);
    send_item(OP_RSVD6, 32'hFFFF_FFFF, 4'd15);
    pause_sender(3);
    send_item(OP_RSVD7, 32'h5555_AAAA, 4'd5);
    send_item(OP_PUSH_BACK, 32'd0, 4'd15);
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_PUSH_FRONT, 32'h8000_0001, 4'd0);
    send_item(OP_PEEK_AT, 32'd0, 4'd2);
    send_item(OP_PEEK_AT, 32'd0, 4'd3);
    // The match sits in the last occupied entry.
    send_item(OP_REMOVE_VAL, 32'hFFFF_FFFF, 4'd0);
    pause_sender(1);
    send_item(OP_PUSH_BACK, 32'd0, 4'd0);
    // Two equal entries: only the one nearer the front goes.
    send_item(OP_REMOVE_VAL, 32'd0, 4'd0);
    send_item(OP_PEEK_AT, 32'd0, 4'd1);
    send_item(OP_RSVD6, 32'd0, 4'd0);
    send_item(OP_REMOVE_AT, 32'd0, 4'd0);
    send_item(OP_REMOVE_AT, 32'd0, 4'd0);
    send_item(OP_POP_FRONT, 32'd0, 4'd0);
    send_item(OP_PUSH_FRONT, 32'h1234_5678, 4'd9);
    send_item(OP_POP_FRONT, 32'd0, 4'd0);
  endtask

  task automatic test_fill_and_overflow();
    while (model_entries.size() < DEPTH) begin
      if ($urandom_range(0, 1)) send_item(OP_PUSH_BACK, $urandom, 4'($urandom_range(0, 15)));
      else send_item(OP_PUSH_FRONT, $urandom, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
    end
    send_item(OP_PUSH_FRONT, $urandom, 4'd0);
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_PEEK_AT, 32'd0, 4'd15);
    send_item(OP_PEEK_AT, 32'd0, 4'd0);
    send_item(OP_REMOVE_AT, 32'd0, 4'd15);
    send_item(OP_PUSH_BACK, $urandom, 4'd0);
    send_item(OP_PUSH_FRONT, $urandom, 4'd0);
    send_item(OP_REMOVE_AT, 32'd0, 4'd7);
    send_item(OP_REMOVE_VAL, model_entries[3], 4'd0);
    send_item(OP_REMOVE_VAL, model_entries[model_entries.size() - 1], 4'd0);
    while (model_entries.size() > 0) begin
      send_item(OP_POP_FRONT, $urandom, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 3));
    end
    send_item(OP_POP_FRONT, 32'd0, 4'd0);
  endtask

  task automatic test_random_ops(input int n_items, input int grow_pct);
    int         sent;
    int         burst;
    int         r;
    logic [2:0] op;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        else if (r < 3 + grow_pct) op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else begin
          case ($urandom_range(0, 3))
            0: op = OP_POP_FRONT;
            1: op = OP_PEEK_AT;
            2: op = OP_REMOVE_AT;
            default: op = OP_REMOVE_VAL;
          endcase
        end
        send_item(op, pick_value(), pick_position());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 5));
    end
  endtask

  task automatic test_value_search(input int n_items);
    logic [31:0] search_pool[4];
    int          r;
    search_pool[0] = 32'd0;
    search_pool[1] = 32'd1;
    search_pool[2] = 32'hFFFF_FFFF;
    search_pool[3] = 32'hA5A5_A5A5;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                  search_pool[$urandom_range(0, 3)], 4'($urandom_range(0, 15)));
      end else if (r < 80) begin
        send_item(OP_REMOVE_VAL, search_pool[$urandom_range(0, 3)],
                  4'($urandom_range(0, 15)));
      end else if (r < 90) begin
        send_item(OP_PEEK_AT, $urandom, pick_position());
      end else begin
        send_item(OP_REMOVE_AT, $urandom, pick_position());
      end
      if ($urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    wait_drained();
    stall_mode = STALL_LIGHT;
    test_fill_and_overflow();
    stall_mode = STALL_RUNS;
    test_random_ops(130, 60);
    wait_drained();
    stall_mode = STALL_PERIODIC;
    test_random_ops(130, 45);
    stall_mode = STALL_NONE;
    test_random_ops(130, 25);
    stall_mode = STALL_RUNS;
    test_value_search(100);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_indexed_deque OK");
    end else begin
      $display("tb_indexed_deque NOT OK");
    end
    $finish;
  end

endmodule
